// ----- src/pmrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_pkg
// Shared types, codes and helpers for the PWM motor ramp controller.
// ----------------------------------------------------------------------------
package pmrc_pkg;

  localparam int START_DUTY_PCT_DEF   = 10;
  localparam int MAX_DUTY_PCT_DEF     = 95;
  localparam int UPDATE_PERIOD_MS_DEF = 10;

  localparam int SAMPLE_BITS  = 12;
  localparam int STEP_W       = 10;
  localparam int PCT_W        = 7;
  localparam int TENTHS_W     = 10;
  localparam int PERIOD_W     = 16;
  localparam int DIV_W        = 10;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CNT_W-1:0] CNT_SAT = 4'd15;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_RAISE = 3'd1,
    KIND_LOWER = 3'd2,
    KIND_DECEL = 3'd3,
    KIND_STOP  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RAISE     = 3'd1,
    PH_RAISE_DEC = 3'd2,
    PH_LOWER     = 3'd3,
    PH_LOWER_DEC = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_BRAKE = 2'd0,
    MODE_RAISE = 2'd1,
    MODE_LOWER = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_ACCEL   = 3'd0,
    REG_DOWN_ACCEL = 3'd1,
    REG_UP_DECEL   = 3'd2,
    REG_DOWN_DECEL = 3'd3,
    REG_MAX_UP     = 3'd4,
    REG_MAX_DOWN   = 3'd5,
    REG_OC_LIMIT   = 3'd6,
    REG_PERIOD     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]      up_accel;
    logic [STEP_W-1:0]      down_accel;
    logic [STEP_W-1:0]      up_decel;
    logic [STEP_W-1:0]      down_decel;
    logic [PCT_W-1:0]       max_up;
    logic [PCT_W-1:0]       max_down;
    logic [SAMPLE_BITS-1:0] oc_limit;
    logic [DIV_W-1:0]       period_div;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    mode_t                  mode;
    logic [TENTHS_W-1:0]    duty;
    logic                   oc;
    logic                   oc_changed;
    logic [SAMPLE_BITS-1:0] peak;
    logic                   done;
    logic [PCT_W-1:0]       cmp_pct;
    logic [DIV_W-1:0]       cmp_div;
  } ctrl_st_t;

  // tenths to whole percent, exact for inputs up to 1023
  function automatic logic [PCT_W-1:0] div10(input logic [TENTHS_W-1:0] tenths);
    logic [TENTHS_W+8-1:0] prod;
    prod = {8'd0, tenths} * 18'd205;
    return prod[17:11];
  endfunction

  function automatic logic [PCT_W-1:0] pct_inv(input logic [PCT_W-1:0] pct);
    return (pct >= 7'd100) ? 7'd0 : 7'(7'd100 - pct);
  endfunction

  // period / 100, exact over the full 16-bit range
  function automatic logic [DIV_W-1:0] div100(input logic [PERIOD_W-1:0] period);
    logic [33:0] prod;
    prod = {18'd0, period} * 34'd167773;
    return prod[33:24];
  endfunction

endpackage

// ----- src/pmrc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_cfg_regs
// Configuration register file; keeps the PWM period pre-divided by 100.
// ----------------------------------------------------------------------------
module pmrc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pmrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmrc_pkg::PERIOD_W-1:0]      cfg_wdata,
  output pmrc_pkg::cfg_t                     cfg
);
  import pmrc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx = reg_idx_t'(cfg_index);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{up_accel: '0, down_accel: '0, up_decel: '0, down_decel: '0,
                 max_up: '0, max_down: '0, oc_limit: '1, period_div: '0};
    end else if (cfg_we) begin
      case (idx)
        REG_UP_ACCEL:   cfg_r.up_accel   <= cfg_wdata[STEP_W-1:0];
        REG_DOWN_ACCEL: cfg_r.down_accel <= cfg_wdata[STEP_W-1:0];
        REG_UP_DECEL:   cfg_r.up_decel   <= cfg_wdata[STEP_W-1:0];
        REG_DOWN_DECEL: cfg_r.down_decel <= cfg_wdata[STEP_W-1:0];
        REG_MAX_UP:     cfg_r.max_up     <= cfg_wdata[PCT_W-1:0];
        REG_MAX_DOWN:   cfg_r.max_down   <= cfg_wdata[PCT_W-1:0];
        REG_OC_LIMIT:   cfg_r.oc_limit   <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_PERIOD:     cfg_r.period_div <= div100(cfg_wdata);
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

endmodule

// ----- src/pmrc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_ctrl
// Drive state and single-pass update: tick count, current monitor, ramps.
// ----------------------------------------------------------------------------
module pmrc_ctrl #(
  parameter int START_DUTY_PCT   = pmrc_pkg::START_DUTY_PCT_DEF,
  parameter int MAX_DUTY_PCT     = pmrc_pkg::MAX_DUTY_PCT_DEF,
  parameter int UPDATE_PERIOD_MS = pmrc_pkg::UPDATE_PERIOD_MS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step_en,
  input  logic [2:0]                         kind,
  input  logic [pmrc_pkg::SAMPLE_BITS-1:0]   sample,
  input  pmrc_pkg::cfg_t                     cfg,
  output pmrc_pkg::ctrl_st_t                 st
);
  import pmrc_pkg::*;

  localparam logic [TENTHS_W-1:0] START_TENTHS = TENTHS_W'(START_DUTY_PCT * 10);
  localparam logic [PCT_W-1:0]    START_PCT    = PCT_W'(START_DUTY_PCT);
  localparam logic [PCT_W-1:0]    MAX_PCT      = PCT_W'(MAX_DUTY_PCT);
  localparam logic [CNT_W-1:0]    UPD_CNT      = CNT_W'(UPDATE_PERIOD_MS);

  ctrl_st_t          st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  kind_t               kind_e;
  logic [CNT_W-1:0]    cnt_inc;
  logic                oc_new;
  phase_t              ph_a;
  logic [TENTHS_W-1:0] duty_a;
  logic [STEP_W-1:0]   acc_step, dec_step;
  logic [PCT_W-1:0]    acc_max, acc_clamp;
  logic [TENTHS_W-1:0] lim;
  logic [TENTHS_W:0]   acc_sum, dec_floor;
  logic [TENTHS_W-1:0] acc_res, dec_res;
  logic                dec_end;

  assign kind_e = kind_t'(kind);
  assign st     = st_r;

  always_comb begin
    st_nxt            = st_r;
    cnt_nxt           = cnt_r;
    st_nxt.oc_changed = 1'b0;
    st_nxt.done       = 1'b0;

    cnt_inc  = (cnt_r < CNT_SAT) ? CNT_W'(cnt_r + 1'b1) : cnt_r;
    oc_new   = (sample > cfg.oc_limit);
    ph_a     = oc_new ? PH_IDLE : st_r.phase;
    duty_a   = (oc_new && st_r.phase != PH_IDLE) ? START_TENTHS : st_r.duty;

    acc_step  = (ph_a == PH_RAISE) ? cfg.up_accel : cfg.down_accel;
    acc_max   = (ph_a == PH_RAISE) ? cfg.max_up : cfg.max_down;
    acc_clamp = (acc_max > MAX_PCT) ? MAX_PCT : acc_max;
    lim       = TENTHS_W'(TENTHS_W'(acc_clamp) * TENTHS_W'(10));
    acc_sum   = {1'b0, duty_a} + {1'b0, acc_step};
    acc_res   = (acc_sum > {1'b0, lim}) ? lim : acc_sum[TENTHS_W-1:0];

    dec_step  = (ph_a == PH_RAISE_DEC) ? cfg.up_decel : cfg.down_decel;
    dec_floor = {1'b0, dec_step} + {1'b0, START_TENTHS};
    dec_end   = (duty_a <= START_TENTHS);
    dec_res   = (dec_end || {1'b0, duty_a} <= dec_floor) ? START_TENTHS
                                                         : TENTHS_W'(duty_a - dec_step);

    case (kind_e)
      KIND_TICK: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= UPD_CNT) begin
          cnt_nxt           = '0;
          st_nxt.done       = 1'b1;
          st_nxt.oc         = oc_new;
          st_nxt.oc_changed = st_r.oc ^ oc_new;
          st_nxt.peak       = (sample > st_r.peak) ? sample : st_r.peak;
          st_nxt.phase      = ph_a;
          st_nxt.duty       = duty_a;
          st_nxt.cmp_div    = cfg.period_div;
          case (ph_a)
            PH_RAISE: begin
              st_nxt.duty    = acc_res;
              st_nxt.cmp_pct = div10(acc_res);
            end
            PH_LOWER: begin
              st_nxt.duty    = acc_res;
              st_nxt.cmp_pct = pct_inv(div10(acc_res));
            end
            PH_RAISE_DEC: begin
              st_nxt.duty    = dec_res;
              st_nxt.cmp_pct = div10(dec_res);
              if (dec_end) begin
                st_nxt.phase = PH_IDLE;
                st_nxt.mode  = MODE_BRAKE;
              end
            end
            PH_LOWER_DEC: begin
              st_nxt.duty    = dec_res;
              st_nxt.cmp_pct = pct_inv(div10(dec_res));
              if (dec_end) begin
                st_nxt.phase = PH_IDLE;
                st_nxt.mode  = MODE_BRAKE;
              end
            end
            default: begin
              st_nxt.mode    = MODE_BRAKE;
              st_nxt.cmp_pct = START_PCT;
            end
          endcase
        end
      end
      KIND_RAISE: begin
        if (st_r.phase == PH_IDLE) begin
          st_nxt.cmp_pct = START_PCT;
          st_nxt.cmp_div = cfg.period_div;
          st_nxt.mode    = MODE_RAISE;
          st_nxt.phase   = PH_RAISE;
          st_nxt.duty    = START_TENTHS;
          cnt_nxt        = '0;
        end
      end
      KIND_LOWER: begin
        if (st_r.phase == PH_IDLE) begin
          st_nxt.cmp_pct = pct_inv(div10(START_TENTHS));
          st_nxt.cmp_div = cfg.period_div;
          st_nxt.mode    = MODE_LOWER;
          st_nxt.phase   = PH_LOWER;
          st_nxt.duty    = START_TENTHS;
          cnt_nxt        = '0;
        end
      end
      KIND_DECEL: begin
        if (st_r.phase == PH_LOWER) begin
          st_nxt.phase = PH_LOWER_DEC;
        end else if (st_r.phase == PH_RAISE) begin
          st_nxt.phase = PH_RAISE_DEC;
        end
      end
      KIND_STOP: begin
        if (st_r.phase != PH_IDLE) begin
          st_nxt.mode    = MODE_BRAKE;
          st_nxt.cmp_pct = START_PCT;
          st_nxt.cmp_div = cfg.period_div;
          st_nxt.phase   = PH_IDLE;
          st_nxt.duty    = START_TENTHS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{phase: PH_IDLE, mode: MODE_BRAKE, duty: START_TENTHS, oc: 1'b0,
                 oc_changed: 1'b0, peak: '0, done: 1'b0, cmp_pct: START_PCT,
                 cmp_div: '0};
      cnt_r <= '0;
    end else if (step_en) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_idle_brake: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.mode == MODE_BRAKE))
    else $error("idle phase without brake mode");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.duty <= TENTHS_W'(1000)) && (st_r.cmp_pct <= PCT_W'(100)))
    else $error("duty or compare percent out of range");

  a_changed_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.oc_changed |-> st_r.done)
    else $error("overcurrent change outside an update");

  a_idle_on_overcurrent: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && kind_e == KIND_TICK && cnt_inc >= UPD_CNT && oc_new)
      |=> (st_r.phase == PH_IDLE))
    else $error("overcurrent update left drive running");

endmodule

// ----- src/pwm_motor_ramp_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_motor_ramp_controller
// Bidirectional brushed-motor PWM ramp controller with overcurrent stop.
// ----------------------------------------------------------------------------
// Path: an accepted beat passes the input register, the state update and the
//   compare multiply into the output register.
// Throughput: one beat per cycle; out_ready low holds the output register and
//   fills the earlier stages behind it.
// Reset: synchronous active-low rst_n clears all stages and restores the
//   idle phase, start duty, brake mode and default configuration.
module pwm_motor_ramp_controller #(
  parameter int START_DUTY_PCT   = pmrc_pkg::START_DUTY_PCT_DEF,
  parameter int MAX_DUTY_PCT     = pmrc_pkg::MAX_DUTY_PCT_DEF,
  parameter int UPDATE_PERIOD_MS = pmrc_pkg::UPDATE_PERIOD_MS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmrc_pkg::PERIOD_W-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_kind,
  input  logic [pmrc_pkg::SAMPLE_BITS-1:0] in_current_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_compare_value,
  output logic [1:0]                       out_bridge_mode,
  output logic [2:0]                       out_phase_out,
  output logic [9:0]                       out_duty_tenths_out,
  output logic                             out_overcurrent_now,
  output logic                             out_overcurrent_changed,
  output logic [pmrc_pkg::SAMPLE_BITS-1:0] out_peak_current_out,
  output logic                             out_update_done
);
  import pmrc_pkg::*;

  cfg_t                   cfg;
  ctrl_st_t               st;

  logic                   v0_r, v1_r, out_valid_r;
  logic [2:0]             kind0_r;
  logic [SAMPLE_BITS-1:0] samp0_r;
  logic                   adv1, adv2;

  logic [15:0]            cmp_r;
  logic [1:0]             mode_r;
  logic [2:0]             phase_r;
  logic [9:0]             duty_r;
  logic                   oc_r, chg_r, done_r;
  logic [SAMPLE_BITS-1:0] peak_r;
  logic [DIV_W+PCT_W-1:0] cmp_prod;

  pmrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmrc_ctrl #(
    .START_DUTY_PCT   (START_DUTY_PCT),
    .MAX_DUTY_PCT     (MAX_DUTY_PCT),
    .UPDATE_PERIOD_MS (UPDATE_PERIOD_MS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv1),
    .kind    (kind0_r),
    .sample  (samp0_r),
    .cfg     (cfg),
    .st      (st)
  );

  assign adv2     = v1_r && (!out_valid_r || out_ready);
  assign adv1     = v0_r && (!v1_r || adv2);
  assign in_ready = !v0_r || adv1;
  assign cmp_prod = {{PCT_W{1'b0}}, st.cmp_div} * {{DIV_W{1'b0}}, st.cmp_pct};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (!v1_r || adv2) begin
        v1_r <= adv1;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= adv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind0_r <= in_kind;
      samp0_r <= in_current_sample;
    end
    if (adv2) begin
      cmp_r   <= cmp_prod[15:0];
      mode_r  <= st.mode;
      phase_r <= st.phase;
      duty_r  <= st.duty;
      oc_r    <= st.oc;
      chg_r   <= st.oc_changed;
      peak_r  <= st.peak;
      done_r  <= st.done;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_compare_value       = cmp_r;
  assign out_bridge_mode         = mode_r;
  assign out_phase_out           = phase_r;
  assign out_duty_tenths_out     = duty_r;
  assign out_overcurrent_now     = oc_r;
  assign out_overcurrent_changed = chg_r;
  assign out_peak_current_out    = peak_r;
  assign out_update_done         = done_r;

  a_mid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !out_valid_r) |=> out_valid_r)
    else $error("state stage did not move into empty output register");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && out_valid_r && !out_ready) |-> !adv1)
    else $error("state advanced while pipeline blocked");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM motor ramp controller. A clocked driver
// sends tick and command beats in random bursts. A clocked monitor stalls the
// result channel on its own pattern and compares every result beat, field by
// field, against a beat-level model of the ramp, overcurrent and compare
// logic. The run steps through several register settings, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb_top;
  import pmrc_pkg::*;

  localparam int START_PCT   = START_DUTY_PCT_DEF;
  localparam int START_DUTY  = START_DUTY_PCT_DEF * 10;
  localparam int DUTY_CAP    = MAX_DUTY_PCT_DEF;
  localparam int UPDATE_MS   = UPDATE_PERIOD_MS_DEF;
  localparam int FULL_PCT    = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 40;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [11:0] sample;
  } motor_cmd_t;

  typedef struct {
    logic [15:0] cmp;
    mode_t       mode;
    phase_t      phase;
    logic [9:0]  duty;
    logic        oc;
    logic        oc_chg;
    logic [11:0] peak;
    logic        done;
  } motor_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [11:0] in_current_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_compare_value;
  logic [1:0]  out_bridge_mode;
  logic [2:0]  out_phase_out;
  logic [9:0]  out_duty_tenths_out;
  logic        out_overcurrent_now;
  logic        out_overcurrent_changed;
  logic [11:0] out_peak_current_out;
  logic        out_update_done;

  pwm_motor_ramp_controller DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_kind                 (in_kind),
    .in_current_sample       (in_current_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_compare_value       (out_compare_value),
    .out_bridge_mode         (out_bridge_mode),
    .out_phase_out           (out_phase_out),
    .out_duty_tenths_out     (out_duty_tenths_out),
    .out_overcurrent_now     (out_overcurrent_now),
    .out_overcurrent_changed (out_overcurrent_changed),
    .out_peak_current_out    (out_peak_current_out),
    .out_update_done         (out_update_done)
  );

  always #5 clk = ~clk;

  // register copies
  logic [9:0]  up_accel_set = '0;
  logic [9:0]  down_accel_set = '0;
  logic [9:0]  up_decel_set = '0;
  logic [9:0]  down_decel_set = '0;
  logic [6:0]  max_up_set = '0;
  logic [6:0]  max_down_set = '0;
  logic [11:0] oc_limit_set = 12'hFFF;
  logic [15:0] period_set = '0;

  // controller state
  phase_t      drv_phase = PH_IDLE;
  mode_t       drv_mode = MODE_BRAKE;
  int          duty_now = START_DUTY;
  logic        oc_flag = 1'b0;
  logic [11:0] peak_seen = '0;
  int          ms_count = 0;
  logic [15:0] cmp_now = '0;

  motor_cmd_t motor_cmd_q[$];
  motor_out_t motor_out_q[$];
  int cmds_pushed = 0;
  int err_count = 0;
  int beat_count = 0;
  int cycle_count = 0;

  function automatic logic [15:0] pct_compare(input int pct);
    return 16'((int'(period_set) / FULL_PCT) * pct);
  endfunction

  function automatic logic [15:0] inv_compare(input int tenths);
    int pct;
    pct = tenths / 10;
    return pct_compare(pct >= FULL_PCT ? 0 : FULL_PCT - pct);
  endfunction

  function automatic void halt_drive();
    if (drv_phase != PH_IDLE) begin
      drv_mode  = MODE_BRAKE;
      cmp_now   = pct_compare(START_PCT);
      drv_phase = PH_IDLE;
      duty_now  = START_DUTY;
    end
  endfunction

  function automatic int ramp_up(input int step, input int max_pct);
    int lim;
    lim = (max_pct > DUTY_CAP ? DUTY_CAP : max_pct) * 10;
    return (duty_now + step > lim) ? lim : duty_now + step;
  endfunction

  function automatic int ramp_down(input int step);
    if (duty_now <= START_DUTY) begin
      drv_phase = PH_IDLE;
      return START_DUTY;
    end
    return (duty_now <= step + START_DUTY) ? START_DUTY : duty_now - step;
  endfunction

  function automatic void predict_motor_outputs(input logic [2:0] kind,
                                                input logic [11:0] sample);
    motor_out_t r;
    logic was_oc;
    r.oc_chg = 1'b0;
    r.done = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (ms_count < CNT_SAT) ms_count++;
        if (ms_count >= UPDATE_MS) begin
          if (sample > peak_seen) peak_seen = sample;
          was_oc = oc_flag;
          oc_flag = (sample > oc_limit_set);
          r.oc_chg = was_oc ^ oc_flag;
          if (oc_flag) halt_drive();
          case (drv_phase)
            PH_RAISE: begin
              duty_now = ramp_up(up_accel_set, max_up_set);
              cmp_now = pct_compare(duty_now / 10);
            end
            PH_RAISE_DEC: begin
              duty_now = ramp_down(up_decel_set);
              cmp_now = pct_compare(duty_now / 10);
              if (drv_phase == PH_IDLE) drv_mode = MODE_BRAKE;
            end
            PH_LOWER: begin
              duty_now = ramp_up(down_accel_set, max_down_set);
              cmp_now = inv_compare(duty_now);
            end
            PH_LOWER_DEC: begin
              duty_now = ramp_down(down_decel_set);
              cmp_now = inv_compare(duty_now);
              if (drv_phase == PH_IDLE) drv_mode = MODE_BRAKE;
            end
            default: begin
              drv_mode = MODE_BRAKE;
              cmp_now = pct_compare(START_PCT);
            end
          endcase
          ms_count = 0;
          r.done = 1'b1;
        end
      end
      KIND_RAISE: if (drv_phase == PH_IDLE) begin
        cmp_now   = pct_compare(START_PCT);
        drv_mode  = MODE_RAISE;
        drv_phase = PH_RAISE;
        duty_now  = START_DUTY;
        ms_count  = 0;
      end
      KIND_LOWER: if (drv_phase == PH_IDLE) begin
        cmp_now   = inv_compare(START_DUTY);
        drv_mode  = MODE_LOWER;
        drv_phase = PH_LOWER;
        duty_now  = START_DUTY;
        ms_count  = 0;
      end
      KIND_DECEL: begin
        if (drv_phase == PH_LOWER) drv_phase = PH_LOWER_DEC;
        else if (drv_phase == PH_RAISE) drv_phase = PH_RAISE_DEC;
      end
      KIND_STOP: halt_drive();
      default: ;
    endcase
    r.cmp   = cmp_now;
    r.mode  = drv_mode;
    r.phase = drv_phase;
    r.duty  = 10'(duty_now);
    r.oc    = oc_flag;
    r.peak  = peak_seen;
    motor_out_q.push_back(r);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_UP_ACCEL:   up_accel_set = val[9:0];
      REG_DOWN_ACCEL: down_accel_set = val[9:0];
      REG_UP_DECEL:   up_decel_set = val[9:0];
      REG_DOWN_DECEL: down_decel_set = val[9:0];
      REG_MAX_UP:     max_up_set = val[6:0];
      REG_MAX_DOWN:   max_down_set = val[6:0];
      REG_OC_LIMIT:   oc_limit_set = val[11:0];
      REG_PERIOD:     period_set = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1000;
      2: return 16'($urandom_range(0, 1000));
      default: return 16'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic logic [15:0] pick_max_pct();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12))
                                       : 16'($urandom_range(0, 100));
  endfunction

  task automatic load_phase_config(input int n);
    logic [15:0] v [8];
    if (n == 0) v = '{1000, 1000, 1000, 1000, 100, 100, 2000, 65535};
    else if (n == 1) v = '{default: 0};
    else if (n == PHASES - 1) v = '{0, 1000, 1, 1000, 0, 100, 4095, 65535};
    else begin
      for (int i = 0; i < 4; i++) v[i] = pick_step();
      v[4] = pick_max_pct();
      v[5] = pick_max_pct();
      v[6] = ($urandom_range(0, 2) == 0) ? 16'd4095 : 16'($urandom_range(800, 4095));
      v[7] = ($urandom_range(0, 3) == 0) ? 16'd65535 : 16'($urandom_range(0, 65535));
    end
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 24))
      0: return 12'hFFF;
      1, 2: return 12'($urandom);
      3: return oc_limit_set;
      4: return (oc_limit_set == 12'hFFF) ? oc_limit_set : oc_limit_set + 12'd1;
      default: return 12'($urandom_range(0, oc_limit_set));
    endcase
  endfunction

  function automatic void push_cmd(input logic [2:0] kind, input logic [11:0] sample);
    motor_cmd_t c;
    c.kind = kind;
    c.sample = sample;
    motor_cmd_q.push_back(c);
    cmds_pushed++;
  endfunction

  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++) push_cmd(KIND_TICK, pick_sample());
  endfunction

  function automatic void push_ramp();
    push_cmd($urandom_range(0, 1) ? KIND_RAISE : KIND_LOWER, 12'($urandom));
    push_ticks($urandom_range(5, 90));
    if ($urandom_range(0, 4) == 0) push_cmd(KIND_STOP, 12'($urandom));
    else begin
      if ($urandom_range(0, 3) == 0)
        push_cmd($urandom_range(0, 1) ? KIND_RAISE : KIND_LOWER, 12'($urandom));
      push_cmd(KIND_DECEL, 12'($urandom));
      push_ticks($urandom_range(5, 120));
      if ($urandom_range(0, 2) == 0) push_cmd(KIND_STOP, 12'($urandom));
    end
  endfunction

  function automatic void push_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_cmd(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 12'($urandom));
      else
        push_cmd(3'($urandom), 12'($urandom));
    end
  endfunction

  function automatic void fill_cmds(input int n);
    int stop_at;
    stop_at = cmds_pushed + n;
    while (cmds_pushed < stop_at) begin
      if ($urandom_range(0, 6) == 0) push_noise();
      else push_ramp();
    end
  endfunction

  function automatic void push_directed();
    push_cmd(KIND_TICK, 12'hFFF);
    push_cmd(KIND_STOP, 12'h000);
    push_cmd(KIND_DECEL, 12'hFFF);
    push_cmd(KIND_SPARE_LO, 12'h000);
    push_cmd(KIND_SPARE_HI, 12'hFFF);
    push_cmd(KIND_RAISE, 12'h000);
    push_cmd(KIND_RAISE, 12'h000);
    push_cmd(KIND_LOWER, 12'h000);
    // overcurrent on the update: stop, then idle update
    for (int i = 0; i < UPDATE_MS - 1; i++) push_cmd(KIND_TICK, 12'h000);
    push_cmd(KIND_TICK, 12'hFFF);
    // lower decel ending idle with inverted compare
    push_cmd(KIND_LOWER, 12'h000);
    push_cmd(KIND_DECEL, 12'h000);
    for (int i = 0; i < UPDATE_MS; i++) push_cmd(KIND_TICK, 12'h000);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (motor_cmd_q.size() != 0 || in_valid || motor_out_q.size() != 0);
  endtask

  task automatic report(input string what, input int got, input int want);
    err_count++;
    if (err_count <= REPORT_MAX)
      $display("%0t beat %0d: %s got %0d want %0d", $time, beat_count, what, got, want);
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    motor_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_motor_outputs(in_kind, in_current_sample);
      if (!in_valid || in_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (burst_left > 0 && motor_cmd_q.size() != 0) begin
          c = motor_cmd_q.pop_front();
          in_valid          <= 1'b1;
          in_kind           <= c.kind;
          in_current_sample <= c.sample;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0) gap_left--;
        end
      end
    end
  end

  // monitor
  logic [15:0] ready_mask = 16'hFFFF;
  int mask_age = 0;
  always @(posedge clk) begin
    motor_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beat_count++;
        if (motor_out_q.size() == 0) begin
          report("result beat with nothing pending", 0, 0);
        end else begin
          e = motor_out_q.pop_front();
          if (out_compare_value !== e.cmp)
            report("compare_value", out_compare_value, e.cmp);
          if (out_bridge_mode !== e.mode)
            report("bridge_mode", out_bridge_mode, int'(e.mode));
          if (out_phase_out !== e.phase)
            report("phase_out", out_phase_out, int'(e.phase));
          if (out_duty_tenths_out !== e.duty)
            report("duty_tenths_out", out_duty_tenths_out, e.duty);
          if (out_overcurrent_now !== e.oc)
            report("overcurrent_now", out_overcurrent_now, e.oc);
          if (out_overcurrent_changed !== e.oc_chg)
            report("overcurrent_changed", out_overcurrent_changed, e.oc_chg);
          if (out_peak_current_out !== e.peak)
            report("peak_current_out", out_peak_current_out, e.peak);
          if (out_update_done !== e.done)
            report("update_done", out_update_done, e.done);
        end
      end
      if (mask_age == 0) begin
        mask_age = $urandom_range(20, 150);
        case ($urandom_range(0, 4))
          0, 1: ready_mask = 16'hFFFF;
          2: ready_mask = 16'h0001;
          3: ready_mask = 16'hAAAA;
          default: ready_mask = 16'($urandom) | 16'h0001;
        endcase
      end
      mask_age--;
      ready_mask = {ready_mask[0], ready_mask[15:1]};
      out_ready <= ready_mask[0];
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
      end
      load_phase_config(p);
      @(negedge clk);
      if (p == 0) push_directed();
      fill_cmds(PHASE_BEATS / 2);
      // hold the sender until every result is back
      wait_drained();
      fill_cmds(PHASE_BEATS / 2);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pmrc_pkg.sv
src/pmrc_cfg_regs.sv
src/pmrc_ctrl.sv
src/pwm_motor_ramp_controller.sv
dv/tb_top.sv
